>>> hdl/pcm_pkg.sv
// Shared types, constants and colour helpers for the palette colour mapper.
// No dependencies; imported by the register block and the top level.
`default_nettype none
package pcm_pkg;

  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;
  localparam int SEL_W = 3;
  localparam int VAL_W = 16;
  localparam int WORD_W = 32;

  localparam logic [0:0] REG_PALETTE = 1'b0;

  localparam logic [7:0] ALPHA = 8'hff;
  localparam logic [7:0] HSV_HI = 8'd204;
  localparam logic [7:0] HSV_LO = 8'd112;
  localparam logic [15:0] HUE_MAX = 16'hffff;
  localparam logic [9:0] RAMP_MUL = 10'd918;
  localparam logic [10:0] RAMP_BASE = 11'd1122;
  localparam logic [12:0] DIV10_MUL = 13'd6554;

  typedef enum logic [SEL_W-1:0] {
    PAL_TINT = 3'd0,
    PAL_RAMP = 3'd1,
    PAL_HSV = 3'd2,
    PAL_GRAY_INV = 3'd3,
    PAL_GRAY = 3'd4
  } palette_t;

  typedef enum logic [2:0] {
    SEC_0 = 3'd0,
    SEC_1 = 3'd1,
    SEC_2 = 3'd2,
    SEC_3 = 3'd3,
    SEC_4 = 3'd4,
    SEC_5 = 3'd5
  } sector_t;

  function automatic logic [WORD_W-1:0] fixed_color(input logic [SEL_W-1:0] sel,
                                                     input logic [7:0] lo);
    logic [7:0] inv;
    logic [7:0] red;
    logic [8:0] dbl;
    logic [WORD_W-1:0] word;
    inv = ~lo;
    dbl = {inv, 1'b0};
    word = {24'h000000, ALPHA};
    case (sel)
      PAL_TINT: begin
        red = (lo + 8'h33) | 8'h33;
        word = {red, 8'h11, 8'hff, ALPHA};
      end
      PAL_RAMP: begin
        red = inv | {7'd0, dbl[8]};
        word = {red, dbl[7:0], 8'h70, ALPHA};
      end
      PAL_GRAY_INV: word = {inv, inv, inv, ALPHA};
      PAL_GRAY: word = {lo, lo, lo, ALPHA};
      default: word = {24'h000000, ALPHA};
    endcase
    return word;
  endfunction

endpackage
`default_nettype wire

>>> hdl/palette_colour_mapper_core.sv
// Palette colour mapper top level: four-stage pipeline from pixel value to RGBA word.
// Depends on pcm_pkg and pcm_apb_regs.
//
// Usage:
//   Input channel pixel_valid/pixel_stall carries one 16-bit pixel_value per
//   transaction; output channel rgba_valid/rgba_stall carries one 32-bit
//   rgba_word per transaction, in input order.
//   An accepted value passes through the s1, s2 and s3 registers into the
//   rgba_word register. Throughput is one pixel per cycle when nothing stalls;
//   the hue path (rotate, sector split, constant multiply, divide by ten) is
//   spread over the four register stages so no stage holds more than one
//   constant multiply.
//   When the receiver stalls, the output register holds its word and each
//   stage keeps accepting until its successor is full; pixel_stall rises only
//   when the whole pipeline is occupied.
//   Reset clears all valid bits and sets palette_select to preset 0.
//   The user must write palette_select (APB byte address 0) only while the pipeline
//   is empty, unenforced; the preset travels with each pixel through the stages.
`default_nettype none
module palette_colour_mapper_core
  import pcm_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output logic      [DATA_W-1:0] prdata,
  output logic                   pready,
  input  wire logic              pixel_valid,
  output logic                   pixel_stall,
  input  wire logic [VAL_W-1:0]  pixel_value,
  output logic                   rgba_valid,
  input  wire logic              rgba_stall,
  output logic      [WORD_W-1:0] rgba_word
);

  logic [SEL_W-1:0] palette_select;

  pcm_apb_regs u_regs (
    .clk           (clk),
    .rst           (rst),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .palette_select(palette_select)
  );

  logic s1_v, s2_v, s3_v;
  logic s1_rdy, s2_rdy, s3_rdy, out_rdy;

  logic              s1_hsv, s2_hsv, s3_hsv;
  logic [WORD_W-1:0] s1_base, s2_base, s3_base;
  logic [18:0]       s1_t;
  logic [2:0]        s2_k, s3_k;
  logic [15:0]       s2_g;
  logic [9:0]        s3_q;

  assign out_rdy = !rgba_valid || !rgba_stall;
  assign s3_rdy = !s3_v || out_rdy;
  assign s2_rdy = !s2_v || s3_rdy;
  assign s1_rdy = !s1_v || s2_rdy;
  assign pixel_stall = !s1_rdy;

  // stage 1: hue numerator n = 512*v mod 65535 as a 9-bit rotate, t = 6n
  logic [15:0] n1;
  logic [18:0] t1;
  always_comb begin
    n1 = (pixel_value == HUE_MAX) ? 16'd0 : {pixel_value[6:0], pixel_value[15:7]};
    t1 = {1'b0, n1, 2'b00} + {2'b00, n1, 1'b0};
  end

  // stage 2: sector and fraction by divide by 65535
  logic [16:0] r2;
  logic [2:0]  k2;
  logic [15:0] f2;
  always_comb begin
    r2 = {1'b0, s1_t[15:0]} + {14'd0, s1_t[18:16]};
    if (r2 >= {1'b0, HUE_MAX}) begin
      k2 = s1_t[18:16] + 3'd1;
      f2 = r2[15:0] - HUE_MAX;
    end else begin
      k2 = s1_t[18:16];
      f2 = r2[15:0];
    end
  end

  // stage 3: floor(918*g / 65535)
  logic [25:0] x3;
  logic [16:0] r3;
  logic [9:0]  q3;
  always_comb begin
    x3 = {16'd0, RAMP_MUL} * {10'd0, s2_g};
    r3 = {1'b0, x3[15:0]} + {7'd0, x3[25:16]};
    q3 = (r3 >= {1'b0, HUE_MAX}) ? x3[25:16] + 10'd1 : x3[25:16];
  end

  // stage 4: ramp = (1122 + q) / 10, then place channels by sector
  logic [10:0]       m4;
  logic [23:0]       p4;
  logic [7:0]        ramp;
  logic [7:0]        rr, gg, bb;
  logic [WORD_W-1:0] word4;
  always_comb begin
    m4 = RAMP_BASE + {1'b0, s3_q};
    p4 = {13'd0, m4} * {11'd0, DIV10_MUL};
    ramp = p4[23:16];
    case (s3_k)
      SEC_0: begin rr = HSV_HI; gg = ramp;   bb = HSV_LO; end
      SEC_1: begin rr = ramp;   gg = HSV_HI; bb = HSV_LO; end
      SEC_2: begin rr = HSV_LO; gg = HSV_HI; bb = ramp;   end
      SEC_3: begin rr = HSV_LO; gg = ramp;   bb = HSV_HI; end
      SEC_4: begin rr = ramp;   gg = HSV_LO; bb = HSV_HI; end
      default: begin rr = HSV_HI; gg = HSV_LO; bb = ramp; end
    endcase
    word4 = s3_hsv ? {rr, gg, bb, ALPHA} : s3_base;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
      s2_v <= 1'b0;
      s3_v <= 1'b0;
      rgba_valid <= 1'b0;
    end else begin
      if (s1_rdy) s1_v <= pixel_valid;
      if (s2_rdy) s2_v <= s1_v;
      if (s3_rdy) s3_v <= s2_v;
      if (out_rdy) rgba_valid <= s3_v;
    end
  end

  always_ff @(posedge clk) begin
    if (pixel_valid && s1_rdy) begin
      s1_t <= t1;
      s1_hsv <= (palette_select == PAL_HSV);
      s1_base <= fixed_color(palette_select, pixel_value[7:0]);
    end
    if (s1_v && s2_rdy) begin
      s2_k <= k2;
      s2_g <= k2[0] ? ~f2 : f2;
      s2_hsv <= s1_hsv;
      s2_base <= s1_base;
    end
    if (s2_v && s3_rdy) begin
      s3_q <= q3;
      s3_k <= s2_k;
      s3_hsv <= s2_hsv;
      s3_base <= s2_base;
    end
    if (s3_v && out_rdy) begin
      rgba_word <= word4;
    end
  end

`ifndef NO_ASSERTIONS
  a_sector_range: assert property (@(posedge clk) disable iff (rst)
    s2_v && s2_hsv |-> s2_k <= 3'd5)
    else $error("hue sector out of range");

  a_quot_range: assert property (@(posedge clk) disable iff (rst)
    s3_v && s3_hsv |-> s3_q <= 10'd918)
    else $error("ramp quotient out of range");

  a_s3_hold: assert property (@(posedge clk) disable iff (rst)
    s3_v && !out_rdy |=> s3_v && $stable(s3_q) && $stable(s3_k) && $stable(s3_base))
    else $error("stage 3 lost data under stall");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !rgba_valid && !s1_v && !s2_v && !s3_v)
    else $error("pipeline not empty after reset");
`endif

endmodule
`default_nettype wire

>>> hdl/pcm_apb_regs.sv
// APB register block of the palette colour mapper: holds the palette select.
// Depends on pcm_pkg.
`default_nettype none
module pcm_apb_regs
  import pcm_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output logic      [DATA_W-1:0] prdata,
  output logic                   pready,
  output logic      [SEL_W-1:0]  palette_select
);

  logic hit;

  assign pready = 1'b1;
  assign hit = (paddr[2] == REG_PALETTE);

  always_ff @(posedge clk) begin
    if (rst) begin
      palette_select <= PAL_TINT;
    end else if (psel && penable && pwrite && pready && hit) begin
      palette_select <= pwdata[SEL_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (hit) begin
      prdata = {{(DATA_W-SEL_W){1'b0}}, palette_select};
    end
  end

endmodule
`default_nettype wire
